// ----- rtl/assert_macros.svh -----
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

// Next-cycle implication that also holds through reset.
`define ASSERT_NEXT_ALWAYS(lbl, pre, post) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ----- rtl/gkms_pkg.sv -----
// Types and constants shared by the grid kernel max stamp modules.
package gkms_pkg;

  localparam int CELL_W  = 14;
  localparam int KIDX_W  = 7;
  localparam int VALUE_W = 8;
  localparam int CFG_W   = 8;

  localparam logic [0:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [0:0] REG_GRID_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_STAMP = 2'd3
  } op_t;

  typedef struct packed {
    op_t                        op;
    logic [CELL_W-1:0]          cell_idx;
    logic [KIDX_W-1:0]          kidx;
    logic signed [VALUE_W-1:0]  value;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_to_back_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_to_q_t;

endpackage

// ----- rtl/gkms_front.sv -----
// Front end: accepts input beats, decodes them into commands and queues them.
module gkms_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [31:0]         in_tdata,
  input  logic [1:0]          in_tuser,
  output gkms_pkg::q_to_back_t q_o,
  input  gkms_pkg::back_to_q_t ctl_i
);
  import gkms_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  cmd_t       cmd_in;

  always_comb begin
    cmd_in.op       = op_t'(in_tuser);
    cmd_in.cell_idx = in_tdata[CELL_W-1:0];
    cmd_in.kidx     = in_tdata[CELL_W+KIDX_W-1:CELL_W];
    cmd_in.value    = in_tdata[CELL_W+KIDX_W+VALUE_W-1:CELL_W+KIDX_W];
  end

  // hold off new beats while the queue is full or the grid is swept after reset
  assign in_tready = (cnt_r != 2'd2) && !ctl_i.clearing;
  assign push      = in_tvalid && in_tready;
  assign pop       = ctl_i.pop && (cnt_r != 2'd0);

  assign q_o.valid = (cnt_r != 2'd0);
  assign q_o.cmd   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

// ----- rtl/gkms_back.sv -----
// Back end: grid and kernel memories, stamp sequencer, config and result register.
module gkms_back #(
  parameter int MAX_WIDTH   = 128,
  parameter int MAX_HEIGHT  = 128,
  parameter int KERN_DIM    = 9
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gkms_pkg::q_to_back_t q_i,
  output gkms_pkg::back_to_q_t ctl_o,
  input  logic                 cfg_valid,
  input  logic [0:0]           cfg_index,
  input  logic [7:0]           cfg_data,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,
  output logic                 out_tuser
);
  import gkms_pkg::*;

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int GAW    = $clog2(DEPTH);
  localparam int KDEPTH = KERN_DIM * KERN_DIM;
  localparam int KAW    = $clog2(KDEPTH);
  localparam int RAD    = KERN_DIM / 2;
  localparam int WUW    = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
  localparam int HUW    = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;
  localparam int LW     = $clog2(DEPTH + 1);
  localparam int XW     = (GAW > CELL_W) ? GAW : CELL_W;
  localparam int PW     = XW + 6;
  localparam int CXW    = ((LW > CELL_W) ? LW : CELL_W) + 1;
  localparam int KXW    = ((KAW > KIDX_W) ? KAW : KIDX_W) + 1;
  localparam int CLR_N  = (DEPTH > KDEPTH) ? DEPTH : KDEPTH;
  localparam int CLRW   = $clog2(CLR_N);
  localparam int KCW    = $clog2(KERN_DIM);
  localparam int RCW    = $clog2(RAD + 1);
  localparam int DCW    = $clog2(XW + 1);
  localparam int W_RST  = (MAX_WIDTH < 100) ? MAX_WIDTH : 100;
  localparam int H_RST  = (MAX_HEIGHT < 100) ? MAX_HEIGHT : 100;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_RDOUT, S_DIV, S_PREP, S_SRD, S_SWR
  } state_t;

  // memories
  logic signed [VALUE_W-1:0] gmem [DEPTH];
  logic signed [VALUE_W-1:0] kmem [KDEPTH];
  logic signed [VALUE_W-1:0] g_rdata_r, k_rdata_r;
  logic                      g_we, k_we;
  logic [GAW-1:0]            g_waddr, g_raddr;
  logic [KAW-1:0]            k_waddr, k_raddr;
  logic signed [VALUE_W-1:0] g_wdata, k_wdata;

  state_t                    state_r;
  cmd_t                      cmd_r;
  logic [WUW-1:0]            w_r;
  logic [HUW-1:0]            h_r;
  logic [LW-1:0]             limit_r;
  logic [PW-1:0]             wrad_r;
  logic [CLRW-1:0]           clr_r;
  logic [XW-1:0]             div_q_r;
  logic [DCW-1:0]            div_cnt_r;
  logic [WUW-1:0]            rem_r, ccol_r, col_r, row_col_r;
  logic [RCW-1:0]            prep_cnt_r;
  logic [PW-1:0]             pos_r;
  logic [KCW-1:0]            kx_r, ky_r;
  logic [KAW-1:0]            ki_r;
  logic                      hit_r;
  logic                      out_valid_r;
  logic [VALUE_W-1:0]        out_data_r;
  logic                      out_oor_r;

  logic [WUW-1:0]            cfg_w_clamp;
  logic [HUW-1:0]            cfg_h_clamp;
  logic [XW-1:0]             centre_x;
  logic [CXW-1:0]            cell_x;
  logic                      cell_in;
  logic [KXW-1:0]            kidx_x;
  logic                      kidx_in;
  logic [WUW:0]              rem_sh, rem_sub;
  logic [WUW-1:0]            rem_next;
  logic [WUW-1:0]            col_inc, col_dec;
  logic [WUW:0]              col_diff, col_abs;
  logic                      hit;
  logic                      raise;
  logic                      row_end, last_off;

  // clamp a written width or height to 1..max
  always_comb begin
    cfg_w_clamp = WUW'(cfg_data);
    if (cfg_w_clamp == '0) cfg_w_clamp = WUW'(1);
    else if (cfg_w_clamp > WUW'(MAX_WIDTH)) cfg_w_clamp = WUW'(MAX_WIDTH);
    cfg_h_clamp = HUW'(cfg_data);
    if (cfg_h_clamp == '0) cfg_h_clamp = HUW'(1);
    else if (cfg_h_clamp > HUW'(MAX_HEIGHT)) cfg_h_clamp = HUW'(MAX_HEIGHT);
  end

  always_comb begin
    centre_x = XW'(cmd_r.cell_idx);
    cell_x   = CXW'(cmd_r.cell_idx);
    cell_in  = cell_x < CXW'(limit_r);
    kidx_x   = KXW'(cmd_r.kidx);
    kidx_in  = kidx_x < KXW'(KDEPTH);
    // one remainder bit per cycle
    rem_sh   = {rem_r, div_q_r[XW-1]};
    rem_sub  = rem_sh - {1'b0, w_r};
    rem_next = (rem_sh >= {1'b0, w_r}) ? rem_sub[WUW-1:0] : rem_sh[WUW-1:0];
    col_inc  = (col_r == w_r - WUW'(1)) ? '0 : col_r + WUW'(1);
    col_dec  = (col_r == '0) ? w_r - WUW'(1) : col_r - WUW'(1);
    col_diff = {1'b0, col_r} - {1'b0, ccol_r};
    col_abs  = col_diff[WUW] ? -col_diff : col_diff;
    hit      = !pos_r[PW-1] && (pos_r < PW'(limit_r)) && (col_abs <= (WUW+1)'(RAD));
    raise    = hit_r && (k_rdata_r != '0) && (k_rdata_r > g_rdata_r);
    row_end  = (kx_r == KCW'(KERN_DIM - 1));
    last_off = row_end && (ky_r == KCW'(KERN_DIM - 1));
  end

  always_comb begin
    g_we    = 1'b0;
    g_waddr = pos_r[GAW-1:0];
    g_wdata = k_rdata_r;
    g_raddr = pos_r[GAW-1:0];
    k_we    = 1'b0;
    k_waddr = kidx_x[KAW-1:0];
    k_wdata = cmd_r.value;
    k_raddr = ki_r;
    unique case (state_r)
      S_CLEAR: begin
        g_we    = ({1'b0, clr_r} < (CLRW+1)'(DEPTH));
        g_waddr = clr_r[GAW-1:0];
        g_wdata = '0;
        k_we    = ({1'b0, clr_r} < (CLRW+1)'(KDEPTH));
        k_waddr = clr_r[KAW-1:0];
        k_wdata = '0;
      end
      S_EXEC: begin
        g_raddr = cell_x[GAW-1:0];
        g_waddr = cell_x[GAW-1:0];
        g_wdata = cmd_r.value;
        g_we    = (cmd_r.op == OP_WRITE) && cell_in;
        k_we    = (cmd_r.op == OP_LOAD) && kidx_in;
      end
      S_SWR: g_we = raise;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (g_we) gmem[g_waddr] <= g_wdata;
    g_rdata_r <= gmem[g_raddr];
    if (k_we) kmem[k_waddr] <= k_wdata;
    k_rdata_r <= kmem[k_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      w_r         <= WUW'(W_RST);
      h_r         <= HUW'(H_RST);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_GRID_WIDTH:  w_r <= cfg_w_clamp;
          REG_GRID_HEIGHT: h_r <= cfg_h_clamp;
          default: begin
          end
        endcase
      end
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;

      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + CLRW'(1);
          if (clr_r == CLRW'(CLR_N - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (q_i.valid && !out_valid_r) begin
            cmd_r   <= q_i.cmd;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (cmd_r.op)
            OP_LOAD: begin
              out_valid_r <= 1'b1;
              out_data_r  <= '0;
              out_oor_r   <= 1'b0;
              state_r     <= S_IDLE;
            end
            OP_WRITE: begin
              out_valid_r <= 1'b1;
              out_data_r  <= '0;
              out_oor_r   <= !cell_in;
              state_r     <= S_IDLE;
            end
            OP_READ: begin
              if (cell_in) begin
                state_r <= S_RDOUT;
              end else begin
                out_valid_r <= 1'b1;
                out_data_r  <= '0;
                out_oor_r   <= 1'b1;
                state_r     <= S_IDLE;
              end
            end
            OP_STAMP: begin
              div_q_r   <= centre_x;
              div_cnt_r <= DCW'(XW);
              rem_r     <= '0;
              state_r   <= S_DIV;
            end
          endcase
        end
        S_RDOUT: begin
          out_valid_r <= 1'b1;
          out_data_r  <= g_rdata_r;
          out_oor_r   <= 1'b0;
          state_r     <= S_IDLE;
        end
        S_DIV: begin
          if (div_cnt_r == '0) begin
            ccol_r     <= rem_r;
            col_r      <= rem_r;
            prep_cnt_r <= RCW'(RAD);
            state_r    <= S_PREP;
          end else begin
            rem_r     <= rem_next;
            div_q_r   <= div_q_r << 1;
            div_cnt_r <= div_cnt_r - DCW'(1);
          end
        end
        S_PREP: begin
          // step the column back to the leftmost kernel offset
          if (prep_cnt_r == '0) begin
            row_col_r <= col_r;
            pos_r     <= PW'(centre_x) - wrad_r - PW'(RAD);
            kx_r      <= '0;
            ky_r      <= '0;
            ki_r      <= '0;
            state_r   <= S_SRD;
          end else begin
            col_r      <= col_dec;
            prep_cnt_r <= prep_cnt_r - RCW'(1);
          end
        end
        S_SRD: begin
          hit_r   <= hit;
          state_r <= S_SWR;
        end
        S_SWR: begin
          if (last_off) begin
            out_valid_r <= 1'b1;
            out_data_r  <= '0;
            out_oor_r   <= 1'b0;
            state_r     <= S_IDLE;
          end else begin
            ki_r    <= ki_r + KAW'(1);
            state_r <= S_SRD;
            if (row_end) begin
              kx_r  <= '0;
              ky_r  <= ky_r + KCW'(1);
              pos_r <= pos_r + PW'(w_r) - PW'(KERN_DIM - 1);
              col_r <= row_col_r;
            end else begin
              kx_r  <= kx_r + KCW'(1);
              pos_r <= pos_r + PW'(1);
              col_r <= col_inc;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    limit_r <= LW'(w_r) * LW'(h_r);
    wrad_r  <= PW'(w_r) * PW'(RAD);
  end

  assign ctl_o.pop      = (state_r == S_IDLE) && q_i.valid && !out_valid_r;
  assign ctl_o.clearing = (state_r == S_CLEAR);
  assign out_tvalid     = out_valid_r;
  assign out_tdata      = out_data_r;
  assign out_tuser      = out_oor_r;

endmodule

// ----- rtl/grid_kernel_max_stamp_core.sv -----
// Top level of the occupancy grid kernel max stamp block.
//
//  channel | dir | handshake              | payload
//  in      | in  | in_tvalid / in_tready  | tuser op; tdata cell, kernel index, value
//  out     | out | out_tvalid / out_tready| tdata read value; tuser out of range
//  cfg     | in  | cfg_valid / cfg_ready  | cfg_index register, cfg_data value
//
// Load and write finish in the execute state; read adds a read-out state for the
// registered grid memory port. Stamp runs a bit-serial column remainder, steps the
// column back by the radius, then a read state and a write state per offset.
// After reset a clearing pass over the grid and kernel memories holds in_tready low.
// Two commands queue ahead of the back end; a waiting result stalls the next one.
module grid_kernel_max_stamp_core #(
  parameter int MAX_WIDTH   = 128,
  parameter int MAX_HEIGHT  = 128,
  parameter int KERN_DIM    = 9
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // cell_index[13:0], kernel_index[20:14], value[28:21]
  input  logic [1:0]  in_tuser,   // op[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // read_value[7:0]
  output logic        out_tuser,  // out_of_range[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import gkms_pkg::*;

  q_to_back_t q2b;
  back_to_q_t b2q;

  assign cfg_ready = 1'b1;

  gkms_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_o       (q2b),
    .ctl_i     (b2q)
  );

  gkms_back #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .KERN_DIM    (KERN_DIM)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_i        (q2b),
    .ctl_o      (b2q),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- rtl/gkms_checker.sv -----
// Port-level checks for the grid kernel max stamp block, bound to the top level.
`include "assert_macros.svh"

module gkms_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tuser
);

  // an out-of-range result never carries cell data
  `ASSERT_IMP(oor_zero_data, out_tvalid && out_tuser, out_tdata == 8'd0)
  // the clearing pass keeps the input closed right after reset
  `ASSERT_NEXT_ALWAYS(no_accept_after_reset, !rst_n, !in_tready)
  // a stalled result beat holds
  `ASSERT_NEXT(out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

endmodule

bind grid_kernel_max_stamp_core gkms_checker u_gkms_checker (.*);
